// ----- rtl/lcs_pkg.sv -----
// Shared types and constants for the longest common substring block.
`default_nettype none

package lcs_pkg;

  localparam int ADDR_W = 6;
  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;

  // Capacity of each string in bytes.
  localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2,
    OP_CLEAR         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_CELL,
    S_DONE,
    S_EMIT
  } state_t;

  // Control from the sequencer to the row unit.
  typedef struct packed {
    logic              first_row;
    logic              cell_en;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] raddr;
  } row_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lcs_row_unit.sv -----
// Previous-row memory and the diagonal run-length cell update.
`default_nettype none

module lcs_row_unit (
  input  wire logic              clk,
  input  wire lcs_pkg::row_ctrl_t ctrl,
  input  wire logic              match,
  output logic [lcs_pkg::LEN_W-1:0] run_len
);

  logic [lcs_pkg::LEN_W-1:0] prev_mem [64];
  logic [lcs_pkg::LEN_W-1:0] prev_rd;
  logic [lcs_pkg::LEN_W-1:0] diag;
  logic [lcs_pkg::LEN_W-1:0] above;
  logic [lcs_pkg::LEN_W-1:0] diag_in;

  // Row zero is implied: treat every entry as zero on the first row.
  assign above   = ctrl.first_row ? '0 : prev_rd;
  assign diag_in = (ctrl.col == '0) ? '0 : diag;
  assign run_len = match ? (diag_in + 7'd1) : '0;

  always_ff @(posedge clk) begin
    prev_rd <= prev_mem[ctrl.raddr];
    if (ctrl.cell_en) begin
      prev_mem[ctrl.col] <= run_len;
      // Keep the old value of this column as the next column's diagonal.
      diag <= above;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/longest_common_substring.sv -----
// Top level: string stores, table sequencer and result emitter.
//
// Operations 0, 1 and 3 (append to first, append to second, clear) give no
// result. A compute visits one table cell per cycle through the previous-row
// memory, plus a row state at the start of each row that fetches that row's
// byte of the first string. The longest substring then comes out one byte per
// cycle, each result on the ports for one cycle under result_valid, the first
// one registered in the first emit state after the done state; an empty match
// gives a single result, registered in the done state. busy stays high from
// the accepted compute until the last result has been launched; the receiver
// cannot stall.
`default_nettype none

module longest_common_substring (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    operation,
  input  wire logic [lcs_pkg::CHAR_W-1:0]    char_value,
  output logic                               result_valid,
  output logic [lcs_pkg::CHAR_W-1:0]         out_char,
  output logic [lcs_pkg::LEN_W-1:0]          match_length,
  output logic [lcs_pkg::ADDR_W-1:0]         start_position,
  output logic                               is_last,
  output logic                               is_empty
);

  lcs_pkg::state_t state, state_next;
  lcs_pkg::op_t    op;
  lcs_pkg::row_ctrl_t ctrl;

  logic [lcs_pkg::CHAR_W-1:0] first_mem  [64];
  logic [lcs_pkg::CHAR_W-1:0] second_mem [64];
  logic [lcs_pkg::CHAR_W-1:0] first_rd;
  logic [lcs_pkg::CHAR_W-1:0] second_rd;

  logic [lcs_pkg::LEN_W-1:0]  first_count;
  logic [lcs_pkg::LEN_W-1:0]  second_count;
  logic [lcs_pkg::ADDR_W-1:0] row;
  logic [lcs_pkg::ADDR_W-1:0] col;
  logic [lcs_pkg::LEN_W-1:0]  best_len;
  logic [lcs_pkg::ADDR_W-1:0] best_end;
  logic [lcs_pkg::ADDR_W-1:0] start_pos;
  logic [lcs_pkg::LEN_W-1:0]  emit_k;

  logic                       accept;
  logic                       first_re;
  logic [lcs_pkg::ADDR_W-1:0] first_raddr;
  logic [lcs_pkg::ADDR_W-1:0] sec_raddr;
  logic                       col_last;
  logic                       row_last;
  logic                       emit_last;
  logic [lcs_pkg::LEN_W-1:0]  run_len;

  assign op        = lcs_pkg::op_t'(operation);
  assign busy      = (state != lcs_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign col_last  = (({1'b0, col} + 7'd1) == second_count);
  assign row_last  = (({1'b0, row} + 7'd1) == first_count);
  assign emit_last = ((emit_k + 7'd1) == best_len);

  lcs_row_unit u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .match   (first_rd == second_rd),
    .run_len (run_len)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lcs_pkg::S_IDLE: begin
        if (accept && op == lcs_pkg::OP_COMPUTE) begin
          if (first_count == '0 || second_count == '0) begin
            state_next = lcs_pkg::S_DONE;
          end else begin
            state_next = lcs_pkg::S_ROW;
          end
        end
      end
      lcs_pkg::S_ROW: begin
        state_next = lcs_pkg::S_CELL;
      end
      lcs_pkg::S_CELL: begin
        if (col_last) begin
          state_next = row_last ? lcs_pkg::S_DONE : lcs_pkg::S_ROW;
        end
      end
      lcs_pkg::S_DONE: begin
        state_next = (best_len == '0) ? lcs_pkg::S_IDLE : lcs_pkg::S_EMIT;
      end
      lcs_pkg::S_EMIT: begin
        if (emit_last) begin
          state_next = lcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lcs_pkg::S_IDLE;
      end
    endcase
  end

  // Memory addressing and row-unit control
  always_comb begin
    first_re       = 1'b0;
    first_raddr    = row;
    sec_raddr      = '0;
    ctrl.first_row = (row == '0);
    ctrl.cell_en   = 1'b0;
    ctrl.col       = col;
    case (state)
      lcs_pkg::S_ROW: begin
        first_re = 1'b1;
      end
      lcs_pkg::S_CELL: begin
        sec_raddr    = col + 6'd1;
        ctrl.cell_en = 1'b1;
      end
      lcs_pkg::S_EMIT: begin
        first_re    = 1'b1;
        first_raddr = start_pos + emit_k[lcs_pkg::ADDR_W-1:0];
      end
      default: begin
        first_re = 1'b0;
      end
    endcase
    ctrl.raddr = sec_raddr;
  end

  // String stores
  always_ff @(posedge clk) begin
    if (accept && op == lcs_pkg::OP_APPEND_FIRST && first_count < lcs_pkg::MAX_LEN) begin
      first_mem[first_count[lcs_pkg::ADDR_W-1:0]] <= char_value;
    end
    if (accept && op == lcs_pkg::OP_APPEND_SECOND && second_count < lcs_pkg::MAX_LEN) begin
      second_mem[second_count[lcs_pkg::ADDR_W-1:0]] <= char_value;
    end
    if (first_re) begin
      first_rd <= first_mem[first_raddr];
    end
    second_rd <= second_mem[sec_raddr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lcs_pkg::S_IDLE;
      first_count  <= '0;
      second_count <= '0;
      best_len     <= '0;
      best_end     <= '0;
      start_pos    <= '0;
      row          <= '0;
      col          <= '0;
      emit_k       <= '0;
      result_valid <= 1'b0;
      is_last      <= 1'b0;
      is_empty     <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        lcs_pkg::S_IDLE: begin
          if (accept) begin
            case (op)
              lcs_pkg::OP_APPEND_FIRST: begin
                if (first_count < lcs_pkg::MAX_LEN) begin
                  first_count <= first_count + 7'd1;
                end
              end
              lcs_pkg::OP_APPEND_SECOND: begin
                if (second_count < lcs_pkg::MAX_LEN) begin
                  second_count <= second_count + 7'd1;
                end
              end
              lcs_pkg::OP_COMPUTE: begin
                best_len <= '0;
                best_end <= '0;
                row      <= '0;
              end
              lcs_pkg::OP_CLEAR: begin
                first_count  <= '0;
                second_count <= '0;
                best_len     <= '0;
                best_end     <= '0;
              end
              default: begin
                best_len <= best_len;
              end
            endcase
          end
        end
        lcs_pkg::S_ROW: begin
          col <= '0;
        end
        lcs_pkg::S_CELL: begin
          // Strict compare keeps the first maximum in row-major order.
          if (run_len > best_len) begin
            best_len <= run_len;
            best_end <= row;
          end
          col <= col + 6'd1;
          if (col_last) begin
            row <= row + 6'd1;
          end
        end
        lcs_pkg::S_DONE: begin
          emit_k <= '0;
          if (best_len == '0) begin
            start_pos    <= '0;
            result_valid <= 1'b1;
            is_last      <= 1'b1;
            is_empty     <= 1'b1;
          end else begin
            start_pos <= best_end + 6'd1 - best_len[lcs_pkg::ADDR_W-1:0];
          end
        end
        lcs_pkg::S_EMIT: begin
          result_valid <= 1'b1;
          is_last      <= emit_last;
          is_empty     <= 1'b0;
          emit_k       <= emit_k + 7'd1;
        end
        default: begin
          result_valid <= 1'b0;
        end
      endcase
    end
  end

  assign out_char       = is_empty ? '0 : first_rd;
  assign match_length   = best_len;
  assign start_position = start_pos;

  // A result is only launched from a running transaction.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a running transaction");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_empty) |-> (is_last && match_length == '0))
    else $error("empty result must be the last and carry length zero");

  a_nonempty_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_empty) |-> (match_length != '0))
    else $error("substring byte emitted with zero length");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (first_count <= lcs_pkg::MAX_LEN) && (second_count <= lcs_pkg::MAX_LEN))
    else $error("string count beyond capacity");

  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == lcs_pkg::S_CELL) |->
      (({1'b0, row} < first_count) && ({1'b0, col} < second_count)))
    else $error("table walk outside the loaded strings");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the longest common substring block: loads, clears, computes and result checks.
`timescale 1ns / 100ps

module tb;

  localparam int STR_CAP      = 64;
  localparam int ITEM_TARGET  = 260;
  localparam int LIMIT_CYCLES = 5000000;

  typedef struct packed {
    logic [lcs_pkg::CHAR_W-1:0] ch;
    logic [lcs_pkg::LEN_W-1:0]  len;
    logic [lcs_pkg::ADDR_W-1:0] pos;
    logic                       last;
    logic                       empty;
  } substring_byte_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  lcs_pkg::op_t               operation = lcs_pkg::OP_APPEND_FIRST;
  logic [lcs_pkg::CHAR_W-1:0] char_value = '0;
  logic                       busy;
  logic                       result_valid;
  logic [lcs_pkg::CHAR_W-1:0] out_char;
  logic [lcs_pkg::LEN_W-1:0]  match_length;
  logic [lcs_pkg::ADDR_W-1:0] start_position;
  logic                       is_last;
  logic                       is_empty;

  // Predictor copy of the two strings
  logic [lcs_pkg::CHAR_W-1:0] first_model [STR_CAP];
  logic [lcs_pkg::CHAR_W-1:0] second_model[STR_CAP];
  int                first_len = 0;
  int                second_len = 0;

  substring_byte_t   expected_bytes[$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  int                items_sent = 0;

  longest_common_substring dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .char_value    (char_value),
    .result_valid  (result_valid),
    .out_char      (out_char),
    .match_length  (match_length),
    .start_position(start_position),
    .is_last       (is_last),
    .is_empty      (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Update the string copies and queue the bytes a compute should emit.
  task automatic predict_substring(lcs_pkg::op_t op, logic [lcs_pkg::CHAR_W-1:0] ch);
    int run_prev[STR_CAP];
    int run_cur[STR_CAP];
    int best_len;
    int best_end;
    int first_pos;
    substring_byte_t r;
    case (op)
      lcs_pkg::OP_APPEND_FIRST: begin
        if (first_len < STR_CAP) begin
          first_model[first_len] = ch;
          first_len++;
        end
      end
      lcs_pkg::OP_APPEND_SECOND: begin
        if (second_len < STR_CAP) begin
          second_model[second_len] = ch;
          second_len++;
        end
      end
      lcs_pkg::OP_CLEAR: begin
        first_len = 0;
        second_len = 0;
      end
      default: begin
        best_len = 0;
        best_end = 0;
        foreach (run_prev[j]) run_prev[j] = 0;
        for (int i = 0; i < first_len; i++) begin
          for (int j = 0; j < second_len; j++) begin
            if (first_model[i] == second_model[j]) begin
              run_cur[j] = (j > 0 ? run_prev[j-1] : 0) + 1;
              // strict compare keeps the first maximum in row order
              if (run_cur[j] > best_len) begin
                best_len = run_cur[j];
                best_end = i;
              end
            end else begin
              run_cur[j] = 0;
            end
          end
          for (int j = 0; j < second_len; j++) run_prev[j] = run_cur[j];
        end
        if (best_len == 0) begin
          r.ch    = '0;
          r.len   = '0;
          r.pos   = '0;
          r.last  = 1'b1;
          r.empty = 1'b1;
          expected_bytes.push_back(r);
        end else begin
          first_pos = best_end + 1 - best_len;
          for (int k = 0; k < best_len; k++) begin
            r.ch    = first_model[first_pos + k];
            r.len   = lcs_pkg::LEN_W'(best_len);
            r.pos   = lcs_pkg::ADDR_W'(first_pos);
            r.last  = (k == best_len - 1);
            r.empty = 1'b0;
            expected_bytes.push_back(r);
          end
        end
      end
    endcase
  endtask

  // Send one transaction; insert a random gap between bursts.
  task automatic send_item(lcs_pkg::op_t op, logic [lcs_pkg::CHAR_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    char_value <= ch;
    do @(posedge clk); while (busy);
    predict_substring(op, ch);
    items_sent++;
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    substring_byte_t want;
    if (!rst && result_valid) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: char %h len %0d pos %0d last %b empty %b",
                   out_char, match_length, start_position, is_last, is_empty);
      end else begin
        want = expected_bytes.pop_front();
        if (out_char !== want.ch || match_length !== want.len ||
            start_position !== want.pos || is_last !== want.last ||
            is_empty !== want.empty) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected char %h len %0d pos %0d last %b empty %b",
                     want.ch, want.len, want.pos, want.last, want.empty);
            $display("          got      char %h len %0d pos %0d last %b empty %b",
                     out_char, match_length, start_position, is_last, is_empty);
          end
        end
      end
    end
  end

  task automatic test_directed();
    // empty strings give the single empty result
    send_item(lcs_pkg::OP_COMPUTE, 8'hFF);
    // two runs of length one; the earlier row wins
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'h00);
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'hFF);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'hFF);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'h00);
    send_item(lcs_pkg::OP_COMPUTE, 8'h00);
    send_item(lcs_pkg::OP_CLEAR, 8'hA5);
    send_item(lcs_pkg::OP_COMPUTE, 8'h5A);
    // no byte in common
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'h41);
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'h42);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'h43);
    send_item(lcs_pkg::OP_COMPUTE, 8'h00);
    send_item(lcs_pkg::OP_CLEAR, 8'h00);
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'h55);
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'hAA);
    send_item(lcs_pkg::OP_APPEND_FIRST, 8'h55);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'hAA);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'h55);
    send_item(lcs_pkg::OP_APPEND_SECOND, 8'hAA);
    send_item(lcs_pkg::OP_COMPUTE, 8'h00);
    send_item(lcs_pkg::OP_COMPUTE, 8'hFF);
  endtask

  // Fill both strings past capacity with the same bytes: a full-length match.
  task automatic test_full_strings();
    logic [lcs_pkg::CHAR_W-1:0] pattern[STR_CAP];
    foreach (pattern[k]) pattern[k] = 8'($urandom_range(0, 255));
    send_item(lcs_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < STR_CAP + 2; i++)
      send_item(lcs_pkg::OP_APPEND_FIRST,
                i < STR_CAP ? pattern[i] : 8'($urandom_range(0, 255)));
    for (int i = 0; i < STR_CAP + 1; i++)
      send_item(lcs_pkg::OP_APPEND_SECOND,
                i < STR_CAP ? pattern[i] : 8'($urandom_range(0, 255)));
    send_item(lcs_pkg::OP_COMPUTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_sequences();
    logic [lcs_pkg::CHAR_W-1:0] a[$];
    logic [lcs_pkg::CHAR_W-1:0] b[$];
    logic [lcs_pkg::CHAR_W-1:0] alphabet[3];
    int len_a;
    int len_b;
    int narrow;
    int span;
    int cut;
    int dest;
    int ia;
    int ib;
    wait_drain();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(lcs_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        continue;
      end
      narrow = $urandom_range(0, 1);
      foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
      len_a = ($urandom_range(0, 7) == 0) ? $urandom_range(40, STR_CAP) : $urandom_range(0, 10);
      len_b = ($urandom_range(0, 11) == 0) ? $urandom_range(40, STR_CAP) : $urandom_range(0, 10);
      a.delete();
      b.delete();
      repeat (len_a)
        a.push_back(narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom_range(0, 255)));
      repeat (len_b)
        b.push_back(narrow ? alphabet[$urandom_range(0, 2)] : 8'($urandom_range(0, 255)));
      // plant a run of the first string in the second; take it from the tail of long ones
      if (len_a > 0 && len_b > 0 && $urandom_range(0, 1) == 1) begin
        span = $urandom_range(1, len_a < len_b ? len_a : len_b);
        cut  = (len_a >= 40) ? len_a - span : $urandom_range(0, len_a - span);
        dest = $urandom_range(0, len_b - span);
        for (int k = 0; k < span; k++) b[dest + k] = a[cut + k];
      end
      if ($urandom_range(0, 9) != 0)
        send_item(lcs_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
      ia = 0;
      ib = 0;
      // interleave the loads of the two strings
      while (ia < a.size() || ib < b.size()) begin
        if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 1)) begin
          send_item(lcs_pkg::OP_APPEND_FIRST, a[ia]);
          ia++;
        end else begin
          send_item(lcs_pkg::OP_APPEND_SECOND, b[ib]);
          ib++;
        end
      end
      send_item(lcs_pkg::OP_COMPUTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0)
        send_item(lcs_pkg::OP_COMPUTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) wait_drain();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_strings();
    test_random_sequences();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lcs_pkg.sv
rtl/lcs_row_unit.sv
rtl/longest_common_substring.sv
dv/tb.sv
